@@ rtl/core/mlfq_pkg.sv @@
// Shared constants, codes and state type for the feedback-queue thread scheduler.
// No dependencies; mlfq_if and mlfq_thread_scheduler depend on this package.
`timescale 1ns / 1ps

package mlfq_pkg;

    localparam int MAX_THREADS = 128;
    localparam int NUM_LEVELS  = 4;
    localparam int NUM_QUEUES  = NUM_LEVELS + 1;

    localparam int ID_W   = 7;
    localparam int LVL_W  = 2;
    localparam int PTR_W  = $clog2(MAX_THREADS);
    localparam int CNT_W  = PTR_W + 1;
    localparam int QSEL_W = $clog2(NUM_QUEUES);
    localparam int CMD_W  = 3;

    localparam int STORE_DEPTH = NUM_QUEUES * MAX_THREADS;
    localparam int TL_DEPTH    = 128;

    localparam logic [LVL_W-1:0]  TOP_LEVEL = LVL_W'(NUM_LEVELS - 1);
    localparam logic [QSEL_W-1:0] BLOCKED_Q = QSEL_W'(NUM_LEVELS);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_THREADS);

    typedef logic [CMD_W-1:0] cmd_code_t;
    localparam cmd_code_t CMD_CREATE  = 3'd0;
    localparam cmd_code_t CMD_EXPIRE  = 3'd1;
    localparam cmd_code_t CMD_YIELD   = 3'd2;
    localparam cmd_code_t CMD_BLOCK   = 3'd3;
    localparam cmd_code_t CMD_EXIT    = 3'd4;
    localparam cmd_code_t CMD_RELEASE = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DISP,
        ST_DISP_ID,
        ST_DISP_LVL,
        ST_REL_RD,
        ST_REL_ID,
        ST_REL_ENQ,
        ST_DONE
    } sched_state_t;

endpackage

@@ rtl/core/mlfq_if.sv @@
// Valid/ready channel interfaces for scheduler commands and running-thread reports.
// Depends on mlfq_pkg for field widths.
`timescale 1ns / 1ps

interface mlfq_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [mlfq_pkg::CMD_W-1:0]      command;
    logic [mlfq_pkg::ID_W-1:0]       thread_id;

    modport source (output valid, output command, output thread_id, input ready);
    modport sink   (input valid, input command, input thread_id, output ready);
endinterface

interface mlfq_run_if;
    logic                            valid;
    logic                            ready;
    logic                            running_valid;
    logic [mlfq_pkg::ID_W-1:0]       running_thread;
    logic [mlfq_pkg::LVL_W-1:0]      running_level;
    logic                            queue_full;

    modport source (output valid, output running_valid, output running_thread,
                    output running_level, output queue_full, input ready);
    modport sink   (input valid, input running_valid, input running_thread,
                    input running_level, input queue_full, output ready);
endinterface

@@ rtl/core/mlfq_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps

module mlfq_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/mlfq_thread_scheduler.sv @@
// Top level of the feedback-queue thread scheduler: sequencer, queue pointers, memories.
// Depends on mlfq_pkg, mlfq_if and mlfq_ram.
`timescale 1ns / 1ps

// One command is taken at a time. Create and unused codes go from the execute step
// straight to the done step; quantum expiry, yield, block and exit add a dispatch
// step and, when a thread is dispatched, a store read, then a level read. Release loops
// once per blocked thread, as each thread needs a store read, a level read and
// a write back through the single ports of the two memories. A new command is
// taken while the previous report still waits on the output. The ready and blocked
// FIFOs share one 640-entry memory; thread levels sit in a 128-entry memory.
// Neither memory is cleared: entries are only read after they are written.
module mlfq_thread_scheduler (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    mlfq_cmd_if.sink      cmd,
    mlfq_run_if.source    run
);
    import mlfq_pkg::*;

    localparam int SAW = QSEL_W + PTR_W;

    sched_state_t     state_reg, state_next;
    logic             fb_reg;
    cmd_code_t        cmd_reg, cmd_next;
    logic [ID_W-1:0]  tid_reg, tid_next;
    logic [PTR_W-1:0] head_reg [NUM_QUEUES];
    logic [PTR_W-1:0] head_next [NUM_QUEUES];
    logic [CNT_W-1:0] count_reg [NUM_QUEUES];
    logic [CNT_W-1:0] count_next [NUM_QUEUES];
    logic [ID_W-1:0]  cur_id_reg, cur_id_next;
    logic             present_reg, present_next;
    logic [LVL_W-1:0] cur_lvl_reg, cur_lvl_next;
    logic             full_reg, full_next;
    logic [ID_W-1:0]  blk_id_reg, blk_id_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_run_reg, out_run_next;
    logic [ID_W-1:0]  out_id_reg, out_id_next;
    logic [LVL_W-1:0] out_lvl_reg, out_lvl_next;
    logic             out_full_reg, out_full_next;

    logic             st_we;
    logic [SAW-1:0]   st_waddr, st_raddr;
    logic [ID_W-1:0]  st_wdata, st_rdata;
    logic             tl_we;
    logic [ID_W-1:0]  tl_waddr, tl_raddr;
    logic [LVL_W-1:0] tl_wdata, tl_rdata;

    logic             enq_en;
    logic [ID_W-1:0]  enq_id;
    logic [LVL_W-1:0] enq_lvl;
    logic             push_en;
    logic [QSEL_W-1:0] push_q;
    logic [ID_W-1:0]  push_id;
    logic             disp_found;
    logic [QSEL_W-1:0] disp_q;
    logic             out_free;

    assign out_free  = !out_valid_reg || run.ready;
    assign cmd.ready = (state_reg == ST_IDLE);

    mlfq_ram #(.DEPTH(STORE_DEPTH), .WIDTH(ID_W)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    mlfq_ram #(.DEPTH(TL_DEPTH), .WIDTH(LVL_W)) u_level (
        .clk   (clk),
        .we    (tl_we),
        .waddr (tl_waddr),
        .wdata (tl_wdata),
        .raddr (tl_raddr),
        .rdata (tl_rdata)
    );

    // highest non-empty level allowed in the current mode
    always_comb
    begin
        disp_found = 1'b0;
        disp_q     = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (count_reg[i] != '0 && (fb_reg || LVL_W'(i) == TOP_LEVEL))
            begin
                disp_found = 1'b1;
                disp_q     = QSEL_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (cmd_reg)
                    CMD_CREATE:  state_next = ST_DONE;
                    CMD_RELEASE: state_next = ST_REL_RD;
                    default:
                    begin
                        if (cmd_reg inside {CMD_EXPIRE, CMD_YIELD, CMD_BLOCK, CMD_EXIT})
                        begin
                            state_next = ST_DISP;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                endcase
            end
            ST_DISP:     state_next = disp_found ? ST_DISP_ID : ST_DONE;
            ST_DISP_ID:  state_next = ST_DISP_LVL;
            ST_DISP_LVL: state_next = ST_DONE;
            ST_REL_RD:   state_next = (count_reg[BLOCKED_Q] != '0) ? ST_REL_ID : ST_DONE;
            ST_REL_ID:   state_next = ST_REL_ENQ;
            ST_REL_ENQ:  state_next = ST_REL_RD;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next     = cmd_reg;
        tid_next     = tid_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        cur_id_next  = cur_id_reg;
        present_next = present_reg;
        cur_lvl_next = cur_lvl_reg;
        full_next    = full_reg;
        blk_id_next  = blk_id_reg;
        out_valid_next = out_valid_reg && !run.ready;
        out_run_next   = out_run_reg;
        out_id_next    = out_id_reg;
        out_lvl_next   = out_lvl_reg;
        out_full_next  = out_full_reg;
        st_raddr = '0;
        tl_raddr = '0;
        enq_en   = 1'b0;
        enq_id   = '0;
        enq_lvl  = '0;
        push_en  = 1'b0;
        push_q   = '0;
        push_id  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next  = cmd.command;
                    tid_next  = cmd.thread_id;
                    full_next = 1'b0;
                end
            end
            ST_EXEC:
            begin
                if (cmd_reg == CMD_CREATE)
                begin
                    enq_en  = 1'b1;
                    enq_id  = tid_reg;
                    enq_lvl = TOP_LEVEL;
                end
                else if (cmd_reg inside {CMD_EXPIRE, CMD_YIELD, CMD_BLOCK, CMD_EXIT}
                         && present_reg)
                begin
                    present_next = 1'b0;
                    enq_id       = cur_id_reg;
                    if (cmd_reg == CMD_EXPIRE)
                    begin
                        enq_en  = 1'b1;
                        enq_lvl = (cur_lvl_reg == '0) ? '0 : cur_lvl_reg - 1'b1;
                    end
                    else if (cmd_reg == CMD_YIELD)
                    begin
                        enq_en  = 1'b1;
                        enq_lvl = cur_lvl_reg;
                    end
                    else if (cmd_reg == CMD_BLOCK)
                    begin
                        push_en = 1'b1;
                        push_q  = BLOCKED_Q;
                        push_id = cur_id_reg;
                    end
                end
            end
            ST_DISP:
            begin
                if (disp_found)
                begin
                    st_raddr          = {disp_q, head_reg[disp_q]};
                    head_next[disp_q]  = head_reg[disp_q] + 1'b1;
                    count_next[disp_q] = count_reg[disp_q] - 1'b1;
                end
            end
            ST_DISP_ID:
            begin
                cur_id_next  = st_rdata;
                present_next = 1'b1;
                tl_raddr     = st_rdata;
            end
            ST_DISP_LVL:
            begin
                cur_lvl_next = tl_rdata;
            end
            ST_REL_RD:
            begin
                if (count_reg[BLOCKED_Q] != '0)
                begin
                    st_raddr              = {BLOCKED_Q, head_reg[BLOCKED_Q]};
                    head_next[BLOCKED_Q]  = head_reg[BLOCKED_Q] + 1'b1;
                    count_next[BLOCKED_Q] = count_reg[BLOCKED_Q] - 1'b1;
                end
                else
                begin
                    head_next[BLOCKED_Q] = '0;
                end
            end
            ST_REL_ID:
            begin
                blk_id_next = st_rdata;
                tl_raddr    = st_rdata;
            end
            ST_REL_ENQ:
            begin
                enq_en  = 1'b1;
                enq_id  = blk_id_reg;
                enq_lvl = tl_rdata;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_run_next   = present_reg;
                    out_id_next    = present_reg ? cur_id_reg : '0;
                    out_lvl_next   = present_reg ? cur_lvl_reg : '0;
                    out_full_next  = full_reg;
                end
            end
            default:
            begin
            end
        endcase

        // ready enqueue: record the level, then push at that level
        tl_we    = enq_en;
        tl_waddr = enq_id;
        tl_wdata = fb_reg ? enq_lvl : TOP_LEVEL;
        if (enq_en)
        begin
            if (enq_id == cur_id_reg)
            begin
                cur_lvl_next = tl_wdata;
            end
            push_en = 1'b1;
            push_q  = QSEL_W'(tl_wdata);
            push_id = enq_id;
        end

        st_we    = 1'b0;
        st_waddr = {push_q, head_reg[push_q] + count_reg[push_q][PTR_W-1:0]};
        st_wdata = push_id;
        if (push_en)
        begin
            if (count_reg[push_q] >= CNT_FULL)
            begin
                full_next = 1'b1;
            end
            else
            begin
                st_we              = 1'b1;
                count_next[push_q] = count_reg[push_q] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fb_reg        <= 1'b1;
            head_reg      <= '{default: '0};
            count_reg     <= '{default: '0};
            cur_id_reg    <= '0;
            present_reg   <= 1'b0;
            cur_lvl_reg   <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                fb_reg <= cfg_wdata;
            end
            head_reg      <= head_next;
            count_reg     <= count_next;
            cur_id_reg    <= cur_id_next;
            present_reg   <= present_next;
            cur_lvl_reg   <= cur_lvl_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        tid_reg      <= tid_next;
        blk_id_reg   <= blk_id_next;
        out_run_reg  <= out_run_next;
        out_id_reg   <= out_id_next;
        out_lvl_reg  <= out_lvl_next;
        out_full_reg <= out_full_next;
    end

    assign run.valid          = out_valid_reg;
    assign run.running_valid  = out_run_reg;
    assign run.running_thread = out_id_reg;
    assign run.running_level  = out_lvl_reg;
    assign run.queue_full     = out_full_reg;

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("report raised outside the done step");

    a_idle_report: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_run_reg) |-> (out_id_reg == '0 && out_lvl_reg == '0))
        else $error("idle report carries a thread");

    a_blk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[BLOCKED_Q] <= CNT_FULL)
        else $error("blocked list overfilled");

    a_release_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REL_RD && count_reg[BLOCKED_Q] == '0) |=>
            head_reg[BLOCKED_Q] == '0)
        else $error("blocked head not rewound after release");

endmodule
